// ----- design/qsb_pkg.sv -----
// ----------------------------------------------------------------------------
// qsb_pkg
// Operation and status codes shared by the multi-queue shared buffer.
// ----------------------------------------------------------------------------
package qsb_pkg;

   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;

   localparam op_type OP_ENQ  = 2'd0;
   localparam op_type OP_DEQ  = 2'd1;
   localparam op_type OP_PEEK = 2'd2;

   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_FULL  = 2'd1;
   localparam status_type STAT_EMPTY = 2'd2;

endpackage

// ----- design/multi_queue_shared_buffer.sv -----
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer
// Several FIFO queues kept as linked lists in one shared payload store, with
// freed entries on a linked free list and untouched ones handed out in order.
// ----------------------------------------------------------------------------
//  channel   direction   handshake              payload
//  req_      in          req_valid/req_ready    operation, queue_id, data_in
//  rsp_      out         rsp_valid/rsp_ready    data_out, status
//
//  Each word is handled in S_IDLE, which reads the link and payload RAMs at
//  the head or free pointer, and then in S_EXEC, which writes the link RAM back
//  and updates the pointers. One word is in flight at a time.
//  A word may be accepted while the previous result waits on rsp_ready; its
//  S_EXEC step then holds until the result register drains.
//  Reset is synchronous and takes effect at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer #(
   parameter int ENTRIES    = 16,
   parameter int QUEUES     = 4,
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_operation,
   input  logic [1:0]                   req_queue_id,
   input  logic signed [DATA_WIDTH-1:0] req_data_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_data_out,
   output logic [1:0]                   rsp_status
);

   localparam int PW = $clog2(ENTRIES + 1);
   localparam int AW = $clog2(ENTRIES);
   localparam int QN = (QUEUES < 4) ? QUEUES : 4;
   localparam int QW = (QN > 1) ? $clog2(QN) : 1;
   localparam logic [PW-1:0] NIL = PW'(ENTRIES);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type                 state_ff, state_in;
   qsb_pkg::op_type           op_ff, op_in;
   logic [QW-1:0]             q_ff, q_in;
   logic [PW-1:0]             slot_ff, slot_in;
   logic                      hit_ff, hit_in;
   logic                      was_empty_ff, was_empty_in;
   qsb_pkg::status_type       status_ff, status_in;
   logic [PW-1:0]             head_ff [QN];
   logic [PW-1:0]             head_in [QN];
   logic [PW-1:0]             tail_ff [QN];
   logic [PW-1:0]             tail_in [QN];
   logic [PW-1:0]             free_ff, free_in;
   logic [PW-1:0]             fresh_ff, fresh_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]     rsp_data_ff, rsp_data_in;
   qsb_pkg::status_type       rsp_status_ff, rsp_status_in;

   logic                      accept;
   logic                      q_ok;
   logic [QW-1:0]             q_idx;
   logic                      is_enq;
   logic                      is_rd;
   logic [PW-1:0]             slot;
   logic                      go;
   qsb_pkg::status_type       status_now;
   logic                      advance;

   logic                      link_we;
   logic [AW-1:0]             link_wa;
   logic [PW-1:0]             link_wd;
   logic [PW-1:0]             link_rd;
   logic                      pay_we;
   logic [DATA_WIDTH-1:0]     pay_rd;

   assign req_ready    = (state_ff == S_IDLE);
   assign accept       = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign advance      = !rsp_valid_ff || rsp_ready;

   assign q_ok   = ({30'd0, req_queue_id} < 32'(QUEUES));
   assign q_idx  = q_ok ? QW'(req_queue_id) : '0;
   assign is_enq = (req_operation == qsb_pkg::OP_ENQ);
   assign is_rd  = req_operation inside {qsb_pkg::OP_DEQ, qsb_pkg::OP_PEEK};
   assign slot   = is_enq ? free_ff : head_ff[q_idx];
   assign go     = q_ok && (is_enq || is_rd) && (slot != NIL);

   always_comb begin
      if (!(is_enq || is_rd)) begin
         status_now = qsb_pkg::STAT_OK;
      end else if (!q_ok) begin
         status_now = qsb_pkg::STAT_EMPTY;
      end else if (slot == NIL) begin
         status_now = is_enq ? qsb_pkg::STAT_FULL : qsb_pkg::STAT_EMPTY;
      end else begin
         status_now = qsb_pkg::STAT_OK;
      end
   end

   qsb_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_link_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (AW'(slot)),
      .rd_data (link_rd),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd)
   );

   qsb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ENTRIES)) u_payload_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (AW'(slot)),
      .rd_data (pay_rd),
      .wr_en   (pay_we),
      .wr_addr (AW'(slot)),
      .wr_data (req_data_in)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      q_in          = q_ff;
      slot_in       = slot_ff;
      hit_in        = hit_ff;
      was_empty_in  = was_empty_ff;
      status_in     = status_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      fresh_in      = fresh_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      link_we       = 1'b0;
      link_wa       = AW'(slot);
      link_wd       = NIL;
      pay_we        = 1'b0;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in     = S_EXEC;
               op_in        = req_operation;
               q_in         = q_idx;
               slot_in      = slot;
               hit_in       = go;
               was_empty_in = (head_ff[q_idx] == NIL);
               status_in    = status_now;
               // claim the slot: terminate its link and store the word
               if (go && is_enq) begin
                  link_we = 1'b1;
                  pay_we  = 1'b1;
               end
            end
         end
         S_EXEC: begin
            if (advance) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = (hit_ff && (op_ff != qsb_pkg::OP_ENQ)) ? pay_rd : '0;
               if (hit_ff && (op_ff == qsb_pkg::OP_ENQ)) begin
                  if (was_empty_ff) begin
                     head_in[q_ff] = slot_ff;
                  end else begin
                     link_we = 1'b1;
                     link_wa = AW'(tail_ff[q_ff]);
                     link_wd = slot_ff;
                  end
                  tail_in[q_ff] = slot_ff;
                  if (slot_ff == fresh_ff) begin
                     free_in  = slot_ff + PW'(1);
                     fresh_in = fresh_ff + PW'(1);
                  end else begin
                     free_in = link_rd;
                  end
               end else if (hit_ff && (op_ff == qsb_pkg::OP_DEQ)) begin
                  head_in[q_ff] = link_rd;
                  link_we       = 1'b1;
                  link_wa       = AW'(slot_ff);
                  link_wd       = free_ff;
                  free_in       = slot_ff;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         free_ff      <= '0;
         fresh_ff     <= '0;
         for (int i = 0; i < QN; i++) begin
            head_ff[i] <= NIL;
            tail_ff[i] <= NIL;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_ff      <= free_in;
         fresh_ff     <= fresh_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
      op_ff         <= op_in;
      q_ff          <= q_in;
      slot_ff       <= slot_in;
      hit_ff        <= hit_in;
      was_empty_ff  <= was_empty_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result raised outside the writeback cycle");

   a_full_means_no_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == qsb_pkg::STAT_FULL)) |-> (free_ff == NIL))
      else $error("full reported while the free list is not empty");

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != qsb_pkg::STAT_OK)) |-> (rsp_data_ff == '0))
      else $error("nonzero data with an error status");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      (fresh_ff <= NIL) && ((free_ff <= fresh_ff) || (free_ff == NIL)))
      else $error("free pointer beyond the untouched region");

endmodule

// ----- design/qsb_ram.sv -----
// ----------------------------------------------------------------------------
// qsb_ram
// Single-port-write, single-port-read synchronous RAM, read-first, with
// registered read data.
// ----------------------------------------------------------------------------
module qsb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

endmodule

// ----- verif/multi_queue_shared_buffer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_tb
// Self-checking bench for the multi-queue shared buffer. A local linked-list
// model of the queues, the free list and the payload store predicts the
// result of every accepted request word; a monitor compares each response
// word in order. Directed corner cases, a fill-to-full pass, a long output
// stall and biased random traffic run in turn under random idling.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_tb;

   localparam int ENTRIES     = 16;
   localparam int QUEUES      = 4;
   localparam int DATA_WIDTH  = 32;
   localparam int PTR_W       = 5;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_WORDS = 980;
   localparam int MAX_SHOWN   = 10;

   localparam logic [PTR_W-1:0] NULL_PTR  = PTR_W'(ENTRIES);
   localparam qsb_pkg::op_type  OP_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] data;
      qsb_pkg::status_type          status;
   } queue_result_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [1:0]                   req_operation;
   logic [1:0]                   req_queue_id;
   logic signed [DATA_WIDTH-1:0] req_data_in;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [DATA_WIDTH-1:0] rsp_data_out;
   logic [1:0]                   rsp_status;

   logic signed [DATA_WIDTH-1:0] slot_payload [ENTRIES];
   logic [PTR_W-1:0]             slot_link [ENTRIES];
   logic [PTR_W-1:0]             head_ptr [QUEUES];
   logic [PTR_W-1:0]             tail_ptr [QUEUES];
   logic [PTR_W-1:0]             free_ptr;
   int                           used_slots;

   queue_result_type pending_results [$];
   queue_result_type oldest_result;

   int error_count;
   int cycle_count;
   int rsp_hold_cycles;
   int tx_steady_left;
   int rx_stall_left;
   int rx_steady_left;

   multi_queue_shared_buffer #(
      .ENTRIES    (ENTRIES),
      .QUEUES     (QUEUES),
      .DATA_WIDTH (DATA_WIDTH)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_queue_id  (req_queue_id),
      .req_data_in   (req_data_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_out  (rsp_data_out),
      .rsp_status    (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("multi_queue_shared_buffer verification failed");
         $finish;
      end
   end

   function automatic int draw_idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      else if (pick < 88)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 40);
   endfunction

   task automatic clear_queue_model();
      for (int i = 0; i < ENTRIES; i++) begin
         slot_payload[i] = '0;
         slot_link[i]    = (i == ENTRIES - 1) ? NULL_PTR : PTR_W'(i + 1);
      end
      for (int q = 0; q < QUEUES; q++) begin
         head_ptr[q] = NULL_PTR;
         tail_ptr[q] = NULL_PTR;
      end
      free_ptr   = '0;
      used_slots = 0;
   endtask

   // Linked-list update for one word; returns the response it must produce.
   function automatic queue_result_type apply_queue_op(
         input qsb_pkg::op_type              op,
         input logic [1:0]                   qid,
         input logic signed [DATA_WIDTH-1:0] din);
      queue_result_type res;
      logic [PTR_W-1:0] slot;
      res.data   = '0;
      res.status = qsb_pkg::STAT_OK;
      if (op == qsb_pkg::OP_ENQ || op == qsb_pkg::OP_DEQ || op == qsb_pkg::OP_PEEK) begin
         if (int'(qid) >= QUEUES) begin
            res.status = qsb_pkg::STAT_EMPTY;
         end else if (op == qsb_pkg::OP_ENQ) begin
            slot = free_ptr;
            if (slot == NULL_PTR) begin
               res.status = qsb_pkg::STAT_FULL;
            end else begin
               free_ptr = slot_link[slot];
               if (head_ptr[qid] == NULL_PTR)
                  head_ptr[qid] = slot;
               else
                  slot_link[tail_ptr[qid]] = slot;
               slot_link[slot]    = NULL_PTR;
               tail_ptr[qid]      = slot;
               slot_payload[slot] = din;
               used_slots++;
            end
         end else begin
            slot = head_ptr[qid];
            if (slot == NULL_PTR) begin
               res.status = qsb_pkg::STAT_EMPTY;
            end else begin
               res.data = slot_payload[slot];
               if (op == qsb_pkg::OP_DEQ) begin
                  head_ptr[qid]   = slot_link[slot];
                  slot_link[slot] = free_ptr;
                  free_ptr        = slot;
                  used_slots--;
               end
            end
         end
      end
      return res;
   endfunction

   task automatic send_word(input qsb_pkg::op_type op, input logic [1:0] qid,
                            input logic signed [DATA_WIDTH-1:0] din);
      int gap;
      if (tx_steady_left > 0) begin
         tx_steady_left--;
         gap = 0;
      end else if ($urandom_range(0, 99) < 4) begin
         tx_steady_left = $urandom_range(20, 60);
         gap = 0;
      end else begin
         gap = draw_idle_len();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_queue_id  <= qid;
      req_data_in   <= din;
      do
         @(posedge clock);
      while (!req_ready);
      pending_results.push_back(apply_queue_op(op, qid, din));
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Receiver: long hold-off on request, else random stalls and steady runs.
   always @(posedge clock) begin
      logic ready_next;
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         ready_next = 1'b0;
      end else if (rx_stall_left > 0) begin
         rx_stall_left--;
         ready_next = 1'b0;
      end else if (rx_steady_left > 0) begin
         rx_steady_left--;
         ready_next = 1'b1;
      end else if ($urandom_range(0, 99) < 5) begin
         rx_steady_left = $urandom_range(20, 80);
         ready_next = 1'b1;
      end else begin
         rx_stall_left = draw_idle_len();
         ready_next = (rx_stall_left == 0);
      end
      rsp_ready <= ready_next;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_SHOWN)
               $display("unexpected response word: data_out=%0d status=%0d",
                        rsp_data_out, rsp_status);
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_data_out !== oldest_result.data ||
                rsp_status !== oldest_result.status) begin
               error_count++;
               if (error_count <= MAX_SHOWN)
                  $display("mismatch: data_out exp %0d got %0d, status exp %0d got %0d",
                           oldest_result.data, rsp_data_out,
                           oldest_result.status, rsp_status);
            end
         end
      end
   end

   task automatic test_directed_cases();
      send_word(qsb_pkg::OP_PEEK, 2'd0, 32'sh1111_1111);
      send_word(qsb_pkg::OP_DEQ, 2'd3, 32'sh2222_2222);
      send_word(OP_UNUSED, 2'd2, 32'sh5555_5555);
      send_word(qsb_pkg::OP_ENQ, 2'd0, 32'sh7FFF_FFFF);
      send_word(qsb_pkg::OP_ENQ, 2'd1, 32'sh8000_0000);
      send_word(qsb_pkg::OP_ENQ, 2'd2, -32'sd1);
      send_word(qsb_pkg::OP_ENQ, 2'd3, 32'sd0);
      send_word(qsb_pkg::OP_ENQ, 2'd0, 32'shAAAA_AAAA);
      send_word(OP_UNUSED, 2'd3, -32'sd1);
      send_word(qsb_pkg::OP_PEEK, 2'd0, 32'sd0);
      send_word(qsb_pkg::OP_DEQ, 2'd0, 32'sd0);
      send_word(qsb_pkg::OP_DEQ, 2'd0, 32'sd0);
      // queue 0 is empty with a stale tail; refill it
      send_word(qsb_pkg::OP_DEQ, 2'd0, 32'sd0);
      send_word(qsb_pkg::OP_PEEK, 2'd0, 32'sd0);
      send_word(qsb_pkg::OP_ENQ, 2'd0, 32'sh1234_5678);
      send_word(qsb_pkg::OP_PEEK, 2'd0, 32'sd0);
      send_word(qsb_pkg::OP_PEEK, 2'd1, 32'sd0);
      send_word(qsb_pkg::OP_DEQ, 2'd2, 32'sd0);
      send_word(qsb_pkg::OP_PEEK, 2'd2, 32'sd0);
   endtask

   task automatic test_buffer_full();
      while (used_slots < ENTRIES)
         send_word(qsb_pkg::OP_ENQ, 2'($urandom_range(0, QUEUES - 1)), $urandom);
      send_word(qsb_pkg::OP_ENQ, 2'd3, $urandom);
      send_word(qsb_pkg::OP_ENQ, 2'd0, $urandom);
      send_word(qsb_pkg::OP_PEEK, 2'($urandom_range(0, QUEUES - 1)), $urandom);
      for (int q = 0; q < QUEUES; q++)
         while (head_ptr[q] != NULL_PTR)
            send_word(qsb_pkg::OP_DEQ, 2'(q), $urandom);
      send_word(qsb_pkg::OP_DEQ, 2'd1, $urandom);
   endtask

   task automatic test_output_backpressure();
      wait_all_results();
      rsp_hold_cycles = 300;
      for (int i = 0; i < 16; i++)
         send_word((i % 3 == 2) ? qsb_pkg::OP_DEQ : qsb_pkg::OP_ENQ,
                   2'(i % QUEUES), $urandom);
      wait_all_results();
   endtask

   task automatic test_random_traffic(input int count);
      int              enq_pct;
      int              pick;
      qsb_pkg::op_type op;
      for (int i = 0; i < count; i++) begin
         enq_pct = ((i / 48) % 2 == 0) ? 65 : 20;
         pick = $urandom_range(0, 99);
         if (pick < 3)
            op = OP_UNUSED;
         else if (pick < 3 + enq_pct)
            op = qsb_pkg::OP_ENQ;
         else if (pick < 18 + enq_pct)
            op = qsb_pkg::OP_PEEK;
         else
            op = qsb_pkg::OP_DEQ;
         send_word(op, 2'($urandom_range(0, QUEUES - 1)), $urandom);
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = qsb_pkg::OP_ENQ;
      req_queue_id    = 2'd0;
      req_data_in     = '0;
      rsp_ready       = 1'b0;
      error_count     = 0;
      cycle_count     = 0;
      rsp_hold_cycles = 0;
      tx_steady_left  = 0;
      rx_stall_left   = 0;
      rx_steady_left  = 0;
      clear_queue_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_buffer_full();
      test_output_backpressure();
      test_random_traffic(RANDOM_WORDS);

      req_valid <= 1'b0;
      wait_all_results();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("multi_queue_shared_buffer verification clean");
      else
         $display("multi_queue_shared_buffer verification failed");
      $finish;
   end

endmodule

// ----- multi_queue_shared_buffer.f -----
design/qsb_pkg.sv
design/qsb_ram.sv
design/multi_queue_shared_buffer.sv
verif/multi_queue_shared_buffer_tb.sv
